FILE: design/hvu_pkg.sv
`default_nettype none

package hvu_pkg;

	// coordinate width handed to the top level by default
	localparam int COORD_WIDTH_DEF = 20;

	// fixed widths of the stream fields
	localparam int FIELD_W   = 20;
	localparam int NODE_W    = 3;
	localparam int NODES     = 8;
	localparam int FRAMES    = 2;
	localparam int SLOTS     = NODES * FRAMES;
	localparam int VOLUME_W  = 63;

	// stream word layout
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 64;

	localparam int NODE_LO = 0;
	localparam int X_LO    = NODE_LO + NODE_W;
	localparam int Y_LO    = X_LO + FIELD_W;
	localparam int Z_LO    = Y_LO + FIELD_W;

	localparam int USER_ACTION = 0;
	localparam int USER_FRAME  = 1;

	// action codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	// tetrahedra of the split and their count
	localparam int TETRAS   = 5;
	localparam int TETRA_W  = 3;

	// the divisor of the triple product sum
	localparam logic [3:0] DIVISOR = 4'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_MUL,
		S_APPLY,
		S_ACCUM,
		S_START,
		S_DIV,
		S_DONE
	} hvu_state_t;

	// node k of tetrahedron t, node k = 0 being the apex of the edge vectors
	function automatic logic [NODE_W-1:0] tetra_node(input logic [TETRA_W-1:0] t,
		input logic [1:0] k);
		logic [4*NODE_W-1:0] row;
		begin
			unique case (t)
				3'd0: row = {3'd5, 3'd2, 3'd1, 3'd0};
				3'd1: row = {3'd5, 3'd7, 3'd2, 3'd0};
				3'd2: row = {3'd7, 3'd3, 3'd2, 3'd0};
				3'd3: row = {3'd4, 3'd7, 3'd5, 3'd0};
				3'd4: row = {3'd6, 3'd5, 3'd7, 3'd2};
				default: row = '0;
			endcase
			tetra_node = row[k*NODE_W +: NODE_W];
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/hvu_ram.sv
`default_nettype none

module hvu_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/hvu_mul.sv
`default_nettype none

module hvu_mul #(
	parameter int D = 21
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [D:0]     op_a,
	input  wire logic signed [D-1:0]   op_b,
	output logic      signed [2*D:0]   prod_q
);

	// registered signed product, one per enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule

`default_nettype wire

FILE: design/hvu_div6.sv
`default_nettype none

module hvu_div6
	import hvu_pkg::*;
#(
	parameter int N = 69
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [N-1:0] dividend,
	output logic              done_q,
	output logic [N-1:0]      quot_q
);

	localparam int DIGIT_W = 16;
	localparam int DIGITS  = (N + DIGIT_W - 1) / DIGIT_W;
	localparam int WORK_W  = DIGITS * DIGIT_W;
	localparam int X_W     = DIGIT_W + 3;
	localparam int SHIFT   = X_W + 3;
	localparam int RECIP_W = SHIFT - 2;
	localparam int SC_W    = SHIFT + DIGIT_W;
	localparam int CNT_W   = $clog2(DIGITS + 1);

	// ceil(2^SHIFT / 6), exact for every partial dividend below 2^X_W
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << SHIFT) + int'(DIVISOR) - 1) / int'(DIVISOR));

	logic [CNT_W-1:0]   cnt_q;
	logic [WORK_W-1:0]  work_q;
	logic [2:0]         rem_q;
	logic [X_W-1:0]     part;
	logic [SC_W-1:0]    scaled;
	logic [DIGIT_W-1:0] qdig;
	logic [2:0]         rem_next;

	// one quotient digit per cycle, most significant digit first
	always_comb begin
		part     = {rem_q, work_q[WORK_W-1 -: DIGIT_W]};
		scaled   = SC_W'(part) * SC_W'(RECIP);
		qdig     = scaled[SHIFT +: DIGIT_W];
		rem_next = 3'(part - X_W'(qdig) * X_W'(DIVISOR));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIGITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend digits leave at the top while quotient digits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= WORK_W'(dividend);
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			work_q <= {work_q[WORK_W-DIGIT_W-1:0], qdig};
			rem_q  <= rem_next;
		end
	end

	assign quot_q = work_q[N-1:0];

endmodule

`default_nettype wire

FILE: design/hexahedron_volume_unit.sv
`default_nettype none

// hexahedron volume unit: keeps two frames (reference and current) of eight
// node coordinates for one hexahedral element in a 16-entry node memory, and
// on a compute word gives the element volume as the truncated sum of the
// absolute triple products of five tetrahedra (nodes 0-1-2-5, 0-2-7-5,
// 0-2-3-7, 0-5-7-4, 2-7-5-6) divided by six. a load word is taken whenever
// the block is idle and gives no result; nodes never loaded read as zero. a
// compute word runs on one shared signed multiplier: per tetrahedron the four
// nodes are fetched from the single memory read port, twelve multiplications
// form the triple product and its magnitude is added, then a divide by six by
// reciprocal multiplication settles one 16-bit digit of the sum per cycle. a
// compute word keeps s_axis_tready low until its volume enters the output
// register, including any wait for that register to free; a finished volume
// waits in the output register while further load words are taken.
module hexahedron_volume_unit
	import hvu_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// node_index[2:0], coord_x[22:3], coord_y[42:23], coord_z[62:43], zero pad
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action[0], frame[1]
	input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// volume[62:0], zero pad
	output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int W      = COORD_WIDTH;
	localparam int D      = W + 1;           // edge vector component width
	localparam int P      = 2 * D + 1;       // product and cross component width
	localparam int ACC_W  = 3 * D + 3;       // triple product width
	localparam int SUM_W  = ACC_W + 3;       // sum of five magnitudes
	localparam int ADDR_W = $clog2(SLOTS);

	// state and sequencing counters
	hvu_state_t         state_q, state_d;
	logic               frame_q;
	logic [TETRA_W-1:0] tetra_q;
	logic [2:0]         fetch_q;
	logic [1:0]         comp_q;
	logic [1:0]         sub_q;

	// operand and result registers
	logic signed [W-1:0] org_q [3];
	logic signed [D-1:0] a_q [3];
	logic signed [D-1:0] b_q [3];
	logic signed [D-1:0] c_q [3];
	logic signed [P-1:0] cross_q;
	logic [ACC_W-1:0]    acc_q;
	logic [SUM_W-1:0]    sum_q;
	logic [VOLUME_W-1:0] volume_q;
	logic                out_valid_q;

	// node memory and its valid bits
	logic [SLOTS-1:0]    valid_q;
	logic                rd_ok_q;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [3*W-1:0]      ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [3*W-1:0]      ram_rdata;
	logic [3*W-1:0]      node_word;

	// shared multiplier
	logic                mul_en;
	logic signed [D:0]   op_a;
	logic signed [D-1:0] op_b;
	logic signed [P-1:0] prod;

	// divider
	logic                div_start;
	logic                div_done;
	logic [SUM_W-1:0]    quot;

	logic                in_acc;
	logic                load_acc;
	logic                comp_acc;
	logic                out_free;
	logic [ACC_W-1:0]    prod_ext;
	logic [SUM_W-1:0]    acc_ext;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign load_acc = in_acc && (s_axis_tuser[USER_ACTION] == ACT_LOAD);
	assign comp_acc = in_acc && (s_axis_tuser[USER_ACTION] == ACT_COMPUTE);
	assign out_free = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(volume_q);

	// only the low coordinate bits are kept, packed z:y:x
	assign ram_we    = load_acc;
	assign ram_waddr = {s_axis_tuser[USER_FRAME], s_axis_tdata[NODE_LO +: NODE_W]};
	assign ram_wdata = {s_axis_tdata[Z_LO +: W], s_axis_tdata[Y_LO +: W],
		s_axis_tdata[X_LO +: W]};
	assign ram_re    = (state_q == S_FETCH) && (fetch_q < 3'd4);
	assign ram_raddr = {frame_q, tetra_node(tetra_q, fetch_q[1:0])};

	// a node never written reads as zero
	assign node_word = rd_ok_q ? ram_rdata : '0;

	hvu_ram #(
		.WIDTH(3 * W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	hvu_mul #(
		.D(D)
	) u_mul (
		.clk   (clk),
		.en    (mul_en),
		.op_a  (op_a),
		.op_b  (op_b),
		.prod_q(prod)
	);

	hvu_div6 #(
		.N(SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.done_q  (div_done),
		.quot_q  (quot)
	);

	// operand selection: cross component i = a[j]*b[k] - a[k]*b[j], then the
	// cross value times c[i] in a low unsigned half and a high signed half
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (sub_q)
			2'd0: begin
				case (comp_q)
					2'd0: begin op_a = (D+1)'(a_q[1]); op_b = b_q[2]; end
					2'd1: begin op_a = (D+1)'(a_q[2]); op_b = b_q[0]; end
					default: begin op_a = (D+1)'(a_q[0]); op_b = b_q[1]; end
				endcase
			end
			2'd1: begin
				case (comp_q)
					2'd0: begin op_a = (D+1)'(a_q[2]); op_b = b_q[1]; end
					2'd1: begin op_a = (D+1)'(a_q[0]); op_b = b_q[2]; end
					default: begin op_a = (D+1)'(a_q[1]); op_b = b_q[0]; end
				endcase
			end
			2'd2: begin
				op_a = $signed({1'b0, cross_q[D-1:0]});
				case (comp_q)
					2'd0: op_b = c_q[0];
					2'd1: op_b = c_q[1];
					default: op_b = c_q[2];
				endcase
			end
			default: begin
				op_a = cross_q[P-1:D];
				case (comp_q)
					2'd0: op_b = c_q[0];
					2'd1: op_b = c_q[1];
					default: op_b = c_q[2];
				endcase
			end
		endcase
	end

	assign prod_ext = {{(ACC_W-P){prod[P-1]}}, prod};
	assign acc_ext  = {{(SUM_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};

	// sequencer
	always_comb begin
		state_d   = state_q;
		mul_en    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (comp_acc) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				if (fetch_q == 3'd4) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				mul_en  = 1'b1;
				state_d = S_APPLY;
			end
			S_APPLY: begin
				if (sub_q == 2'd3 && comp_q == 2'd2) begin
					state_d = S_ACCUM;
				end else begin
					state_d = S_MUL;
				end
			end
			S_ACCUM: begin
				if (tetra_q == TETRA_W'(TETRAS - 1)) begin
					state_d = S_START;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_START: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			tetra_q     <= '0;
			fetch_q     <= '0;
			comp_q      <= '0;
			sub_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load_acc) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					tetra_q <= '0;
					fetch_q <= '0;
				end
				S_FETCH: begin
					fetch_q <= fetch_q + 1'b1;
					comp_q  <= '0;
					sub_q   <= '0;
				end
				S_APPLY: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd3) begin
						comp_q <= comp_q + 1'b1;
					end
				end
				S_ACCUM: begin
					tetra_q <= tetra_q + 1'b1;
					fetch_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_ok_q <= valid_q[ram_raddr];
		if (comp_acc) begin
			frame_q <= s_axis_tuser[USER_FRAME];
			sum_q   <= '0;
		end
		if (state_q == S_FETCH) begin
			// data of the read issued last cycle
			for (int k = 0; k < 3; k++) begin
				unique case (fetch_q)
					3'd1: org_q[k] <= node_word[k*W +: W];
					3'd2: a_q[k] <= {node_word[k*W+W-1], node_word[k*W +: W]}
						- {org_q[k][W-1], org_q[k]};
					3'd3: b_q[k] <= {node_word[k*W+W-1], node_word[k*W +: W]}
						- {org_q[k][W-1], org_q[k]};
					3'd4: c_q[k] <= {node_word[k*W+W-1], node_word[k*W +: W]}
						- {org_q[k][W-1], org_q[k]};
					default: ;
				endcase
			end
			acc_q <= '0;
		end
		if (state_q == S_APPLY) begin
			case (sub_q)
				2'd0: cross_q <= prod;
				2'd1: cross_q <= cross_q - prod;
				2'd2: acc_q <= acc_q + prod_ext;
				default: acc_q <= acc_q + (prod_ext << D);
			endcase
		end
		if (state_q == S_ACCUM) begin
			// add the magnitude of the triple product
			sum_q <= acc_q[ACC_W-1] ? sum_q - acc_ext : sum_q + acc_ext;
		end
		if (state_q == S_DONE && out_free) begin
			volume_q <= VOLUME_W'(quot);
		end
	end

`ifndef SYNTHESIS
	// a compute word keeps the input side closed on the next cycle
	a_busy_after_compute: assert property (@(posedge clk) disable iff (!arst_n)
		comp_acc |=> !s_axis_tready)
		else $error("input taken during a volume computation");

	// a loaded node is marked valid
	a_load_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> valid_q[$past(ram_waddr)])
		else $error("loaded node not marked valid");

	// a new volume only comes out of the final state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
		else $error("volume presented outside the final state");

	// the divider finishes only while it is awaited
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	// the multiplier is only used between fetches of a tetrahedron
	a_mul_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mul_en |-> (comp_q != 2'd3 && tetra_q < TETRA_W'(TETRAS)))
		else $error("multiplier step out of range");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_hexahedron_volume_unit.sv
module tb_hexahedron_volume_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import hvu_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 480;
	localparam int MAX_REPORTS = 10;

	localparam logic FRAME_REF = 1'b0;
	localparam logic FRAME_CUR = 1'b1;

	localparam logic [FIELD_W-1:0] COORD_MIN = 20'h80000;
	localparam logic [FIELD_W-1:0] COORD_MAX = 20'h7FFFF;

	// the five tetrahedra of the split, apex node first
	localparam logic [NODE_W-1:0] TETRA_CORNERS [TETRAS][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd5},
		'{3'd0, 3'd2, 3'd7, 3'd5},
		'{3'd0, 3'd2, 3'd3, 3'd7},
		'{3'd0, 3'd5, 3'd7, 3'd4},
		'{3'd2, 3'd7, 3'd5, 3'd6}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// own copy of the node memory, indexed {frame, node}, xyz as signed values
	longint node_coords [SLOTS][3];

	// volumes still owed by the block, oldest first
	logic [VOLUME_W-1:0] pending_volumes [$];

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;

	// receiver stall pattern, rotated every cycle and replaced now and then
	logic [15:0] ready_pattern = '1;
	int unsigned pattern_age = 0;

	hexahedron_volume_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver side: stalls on its own rotating pattern, sometimes never
	always @(posedge clk) begin
		if (pattern_age == 0) begin
			pattern_age <= $urandom_range(16, 96);
			if ($urandom_range(0, 3) == 0)
				ready_pattern <= '1;
			else
				ready_pattern <= 16'($urandom) | 16'h0001;
		end else begin
			pattern_age <= pattern_age - 1;
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
		end
		m_axis_tready <= ready_pattern[0];
	end

	// only the low CW bits count, sign-extended from bit CW-1
	function automatic longint coord_value(input logic [FIELD_W-1:0] raw);
		longint v;
		v = longint'(raw) & ((longint'(1) << CW) - 1);
		if (raw[CW-1])
			v = v - (longint'(1) << CW);
		return v;
	endfunction

	// exact sum of the five absolute triple products, divided once by six
	function automatic logic [VOLUME_W-1:0] hex_volume(input logic frm);
		logic [66:0] total;
		longint a [3];
		longint b [3];
		longint c [3];
		longint o;
		longint d;
		total = '0;
		for (int t = 0; t < TETRAS; t++) begin
			for (int k = 0; k < 3; k++) begin
				o = node_coords[{frm, TETRA_CORNERS[t][0]}][k];
				a[k] = node_coords[{frm, TETRA_CORNERS[t][1]}][k] - o;
				b[k] = node_coords[{frm, TETRA_CORNERS[t][2]}][k] - o;
				c[k] = node_coords[{frm, TETRA_CORNERS[t][3]}][k] - o;
			end
			d = (a[1] * b[2] - a[2] * b[1]) * c[0]
			  + (a[2] * b[0] - a[0] * b[2]) * c[1]
			  + (a[0] * b[1] - a[1] * b[0]) * c[2];
			if (d < 0)
				d = -d;
			total = total + 67'(d);
		end
		total = total / 67'd6;
		return total[VOLUME_W-1:0];
	endfunction

	// mix of extremes, small values and the full range so every bit toggles
	function automatic logic [FIELD_W-1:0] rand_coord();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return COORD_MIN;
			1: return COORD_MAX;
			2, 3, 4: return FIELD_W'($signed($urandom_range(0, 127)) - 64);
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	task automatic note_mismatch(input string what, input logic [OUT_DATA_W-1:0] want,
		input logic [OUT_DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch (%s) at cycle %0d: expected %h, got %h", what, cycle_count,
				want, got);
	endtask

	// result checker
	always @(posedge clk) begin
		logic [VOLUME_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_volumes.size() == 0) begin
				note_mismatch("unexpected word", '0, m_axis_tdata);
			end else begin
				want = pending_volumes.pop_front();
				if (m_axis_tdata[VOLUME_W-1:0] !== want)
					note_mismatch("volume", {1'b0, want}, m_axis_tdata);
				if (m_axis_tdata[OUT_DATA_W-1:VOLUME_W] !== '0)
					note_mismatch("pad bits", {1'b0, want}, m_axis_tdata);
			end
		end
	end

	// send one word in bursts with random gaps; predicts at the accepting edge
	task automatic send_word(input logic act, input logic frm, input logic [NODE_W-1:0] node,
		input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
		input logic [FIELD_W-1:0] z);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, z, y, x, node};
		s_axis_tuser  <= {frm, act};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (act == ACT_LOAD) begin
			node_coords[{frm, node}][0] = coord_value(x);
			node_coords[{frm, node}][1] = coord_value(y);
			node_coords[{frm, node}][2] = coord_value(z);
		end else begin
			pending_volumes.push_back(hex_volume(frm));
		end
	endtask

	task automatic load_node(input logic frm, input logic [NODE_W-1:0] node,
		input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
		input logic [FIELD_W-1:0] z);
		send_word(ACT_LOAD, frm, node, x, y, z);
	endtask

	// fields other than the frame are don't-care on a compute word
	task automatic compute(input logic frm);
		send_word(ACT_COMPUTE, frm, NODE_W'($urandom), rand_coord(), rand_coord(),
			rand_coord());
	endtask

	// corner k of the unit hexahedron in the usual node numbering
	function automatic logic [2:0] corner_bits(input logic [NODE_W-1:0] node);
		logic cx;
		logic cy;
		cx = (node == 3'd1) || (node == 3'd2) || (node == 3'd5) || (node == 3'd6);
		cy = (node == 3'd2) || (node == 3'd3) || (node == 3'd6) || (node == 3'd7);
		return {node[2], cy, cx};
	endfunction

	// nothing loaded yet: both frames are all zero, so the volume is zero
	task automatic test_after_reset();
		compute(FRAME_REF);
		compute(FRAME_CUR);
	endtask

	// box spanning the whole coordinate range: the largest volume
	task automatic test_extreme_element();
		logic [2:0] cb;
		for (int n = 0; n < NODES; n++) begin
			cb = corner_bits(NODE_W'(n));
			load_node(FRAME_REF, NODE_W'(n), cb[0] ? COORD_MAX : COORD_MIN,
				cb[1] ? COORD_MAX : COORD_MIN, cb[2] ? COORD_MAX : COORD_MIN);
		end
		compute(FRAME_REF);
	endtask

	// swap two opposite corners: tetrahedra turn inside out, still counted positive
	task automatic test_inverted_element();
		load_node(FRAME_REF, 3'd0, COORD_MAX, COORD_MAX, COORD_MAX);
		load_node(FRAME_REF, 3'd6, COORD_MIN, COORD_MIN, COORD_MIN);
		compute(FRAME_REF);
	endtask

	// one node moved in the otherwise untouched current frame; frames are separate
	task automatic test_partial_frame();
		load_node(FRAME_CUR, 3'd3, COORD_MAX, 20'h00123, COORD_MIN);
		compute(FRAME_CUR);
		compute(FRAME_REF);
	endtask

	// compute with all node and coordinate bits set, then all clear: these fields must be ignored
	task automatic test_compute_ignores_fields();
		send_word(ACT_COMPUTE, FRAME_REF, 3'd7, '1, '1, '1);
		send_word(ACT_COMPUTE, FRAME_CUR, 3'd0, '0, '0, '0);
	endtask

	// mostly whole jittered elements followed by a compute, plus stray loads/computes
	task automatic test_random_traffic();
		int sent;
		int unsigned pick;
		int ox;
		int oy;
		int oz;
		int edge_len;
		logic frm;
		logic [2:0] cb;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			frm = 1'($urandom);
			if (pick < 4) begin
				ox = $signed($urandom_range(0, 400000)) - 200000;
				oy = $signed($urandom_range(0, 400000)) - 200000;
				oz = $signed($urandom_range(0, 400000)) - 200000;
				edge_len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
					: $urandom_range(1, 100000);
				for (int n = 0; n < NODES; n++) begin
					cb = corner_bits(NODE_W'(n));
					load_node(frm, NODE_W'(n),
						FIELD_W'(ox + cb[0] * edge_len + $signed($urandom_range(0, 2000)) - 1000),
						FIELD_W'(oy + cb[1] * edge_len + $signed($urandom_range(0, 2000)) - 1000),
						FIELD_W'(oz + cb[2] * edge_len + $signed($urandom_range(0, 2000)) - 1000));
				end
				compute(frm);
				sent += NODES + 1;
			end else if (pick < 6) begin
				compute(frm);
				sent++;
			end else begin
				load_node(frm, NODE_W'($urandom), rand_coord(), rand_coord(), rand_coord());
				sent++;
			end
		end
	endtask

	initial begin
		for (int s = 0; s < SLOTS; s++)
			for (int k = 0; k < 3; k++)
				node_coords[s][k] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_extreme_element();
		test_inverted_element();
		test_partial_frame();
		test_compute_ignores_fields();
		test_random_traffic();

		s_axis_tvalid <= 1'b0;
		while (pending_volumes.size() != 0)
			@(posedge clk);
		// leave room for a stray extra word after the last compute
		repeat (400) @(posedge clk);

		if (mismatches == 0 && pending_volumes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
